@@ design/dnsr_pkg.sv @@
// shared types and constants for the dns redirect responder
`timescale 1ns / 1ps

package dnsr_pkg;

    // default query length limit in bytes
    localparam int DEF_MAX_PACKET_BYTES = 512;

    // reply buffer size and fixed dns header size
    localparam int REPLY_BYTES  = 512;
    localparam int HEADER_BYTES = 12;

    // reset values of the configuration registers
    localparam logic [31:0] AP_ADDRESS_RESET = 32'hC0A8_0101;
    localparam logic [31:0] ANSWER_TTL_RESET = 32'd5;

    // configuration register indexes
    localparam logic CFG_AP_ADDRESS = 1'b0;
    localparam logic CFG_ANSWER_TTL = 1'b1;

    // query type of an a record
    localparam logic [15:0] QTYPE_A = 16'h0001;

    // action of a reply item
    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_SEND  = 2'd1,
        ACT_DROP  = 2'd2
    } t_action;

    // work handed from the byte walker to the result sequencer for one item
    typedef struct packed {
        logic       echo_v;     // echo write of this byte is emitted
        logic [8:0] echo_off;   // offset of the echo write
        logic [7:0] echo_byte;  // value of the echo write
        logic       eop;        // last byte of the query
        logic       ok;         // reply is sent, else dropped
        logic       is_a;       // a record answer is appended
        logic [8:0] ans_off;    // offset of the first answer byte
        logic [9:0] rlen;       // reply length on send
    } t_job;

endpackage

@@ design/dnsr_parse.sv @@
// query byte walker: header echo, label walk, qtype capture and end of packet checks
`timescale 1ns / 1ps

module dnsr_parse
    import dnsr_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_packet,
    output t_job       o_job,
    output logic       o_job_has
);

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int EXT_W = $clog2(MAX_PACKET_BYTES + 257);

    logic [POS_W-1:0] r_pos,       n_pos;
    logic [EXT_W-1:0] r_next_lbl,  n_next_lbl;
    logic             r_seen,      n_seen;
    logic [POS_W-1:0] r_name_end,  n_name_end;
    logic [15:0]      r_qtype,     n_qtype;
    logic             r_overlong,  n_overlong;

    logic             in_range;
    logic [EXT_W-1:0] p_ext;
    logic [EXT_W-1:0] nea_ext;
    logic [EXT_W-1:0] new_nea_ext;
    logic [EXT_W-1:0] rlen_ext;
    logic             echo;
    logic             ok;
    logic             is_a;

    // walk one byte and work out the end of packet verdict
    always_comb begin
        in_range    = r_pos < POS_W'(MAX_PACKET_BYTES);
        p_ext       = EXT_W'(r_pos);
        nea_ext     = EXT_W'(r_name_end);
        n_pos       = r_pos;
        n_next_lbl  = r_next_lbl;
        n_seen      = r_seen;
        n_name_end  = r_name_end;
        n_qtype     = r_qtype;
        n_overlong  = r_overlong;
        echo        = 1'b0;

        if (!in_range) begin
            n_overlong = 1'b1;
        end else begin
            // id, question count and the question section are echoed
            if (r_pos == POS_W'(0) || r_pos == POS_W'(1) ||
                r_pos == POS_W'(4) || r_pos == POS_W'(5)) begin
                echo = 1'b1;
            end else if (r_pos >= POS_W'(HEADER_BYTES) &&
                         (!r_seen || p_ext <= nea_ext + EXT_W'(4))) begin
                echo = 1'b1;
            end
            // qtype follows the root label, otherwise walk label lengths
            if (r_seen) begin
                if (p_ext == nea_ext + EXT_W'(1)) begin
                    n_qtype = {i_data_byte, r_qtype[7:0]};
                end else if (p_ext == nea_ext + EXT_W'(2)) begin
                    n_qtype = {r_qtype[15:8], i_data_byte};
                end
            end else if (r_pos >= POS_W'(HEADER_BYTES) && p_ext == r_next_lbl) begin
                if (i_data_byte == 8'd0) begin
                    n_seen     = 1'b1;
                    n_name_end = r_pos;
                end else begin
                    n_next_lbl = p_ext + EXT_W'(i_data_byte) + EXT_W'(1);
                end
            end
            n_pos = r_pos + POS_W'(1);
        end

        // verdict on the finished packet
        new_nea_ext = EXT_W'(n_name_end);
        is_a        = n_qtype == QTYPE_A;
        rlen_ext    = new_nea_ext + EXT_W'(5) + (is_a ? EXT_W'(16) : EXT_W'(0));
        ok          = !n_overlong && n_pos >= POS_W'(HEADER_BYTES) && n_seen &&
                      (new_nea_ext + EXT_W'(5) <= EXT_W'(n_pos)) &&
                      (32'(rlen_ext) <= 32'(REPLY_BYTES));
    end

    // job for the result side
    always_comb begin
        o_job.echo_v    = echo && (32'(r_pos) < 32'(REPLY_BYTES));
        o_job.echo_off  = 9'(r_pos);
        o_job.echo_byte = i_data_byte;
        o_job.eop       = i_end_of_packet;
        o_job.ok        = ok;
        o_job.is_a      = is_a;
        o_job.ans_off   = 9'(new_nea_ext + EXT_W'(5));
        o_job.rlen      = 10'(rlen_ext);
        o_job_has       = o_job.echo_v || i_end_of_packet;
    end

    // per packet state, back to its start after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_next_lbl <= EXT_W'(HEADER_BYTES);
            r_seen     <= 1'b0;
            r_name_end <= '0;
            r_qtype    <= '0;
            r_overlong <= 1'b0;
        end else if (i_accept) begin
            if (i_end_of_packet) begin
                r_pos      <= '0;
                r_next_lbl <= EXT_W'(HEADER_BYTES);
                r_seen     <= 1'b0;
                r_name_end <= '0;
                r_qtype    <= '0;
                r_overlong <= 1'b0;
            end else begin
                r_pos      <= n_pos;
                r_next_lbl <= n_next_lbl;
                r_seen     <= n_seen;
                r_name_end <= n_name_end;
                r_qtype    <= n_qtype;
                r_overlong <= n_overlong;
            end
        end
    end

endmodule

@@ design/dnsr_emit.sv @@
// result sequencer: job register, write and send list, output register
`timescale 1ns / 1ps

module dnsr_emit
    import dnsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_job        i_job,
    input  logic [31:0] i_ap_address,
    input  logic [31:0] i_answer_ttl,
    output logic        o_ready,
    input  logic        i_m_tready,
    output logic        o_m_tvalid,
    output logic [31:0] o_m_tdata,   // write_offset[8:0], write_byte[16:9], reply_length[26:17]
    output logic [1:0]  o_m_tuser,   // action
    output logic        o_m_tlast    // final_result
);

    // sequence positions within one job
    localparam logic [4:0] STEP_ECHO     = 5'd0;
    localparam logic [4:0] STEP_HDR0     = 5'd1;
    localparam logic [4:0] STEP_HDR_LAST = 5'd8;
    localparam logic [4:0] STEP_ANS0     = 5'd9;
    localparam logic [4:0] STEP_ANS_LAST = 5'd24;
    localparam logic [4:0] STEP_SEND     = 5'd25;
    localparam logic [4:0] STEP_DROP     = 5'd26;

    t_job        r_job;
    logic        r_job_v;
    logic [4:0]  r_step;
    logic [4:0]  n_step;
    logic [4:0]  start_step;
    logic        r_m_tvalid;
    logic [31:0] r_m_tdata;
    logic [1:0]  r_m_tuser;
    logic        r_m_tlast;

    logic        out_load;
    logic        fire;
    logic        last;
    logic [4:0]  next_step;
    t_action     act;
    logic [8:0]  off;
    logic [7:0]  val;
    logic [9:0]  len;
    logic [2:0]  hdr_idx;
    logic [3:0]  ans_idx;

    assign out_load = !r_m_tvalid || i_m_tready;
    assign fire     = r_job_v && out_load;
    assign o_ready  = !r_job_v || (fire && last);

    // first position of an incoming job
    always_comb begin
        if (i_job.echo_v) begin
            start_step = STEP_ECHO;
        end else if (i_job.ok) begin
            start_step = STEP_HDR0;
        end else begin
            start_step = STEP_DROP;
        end
    end

    // result at the current position and the position after it
    always_comb begin
        hdr_idx   = 3'(r_step - STEP_HDR0);
        ans_idx   = 4'(r_step - STEP_ANS0);
        act       = ACT_WRITE;
        off       = '0;
        val       = '0;
        len       = '0;
        last      = 1'b0;
        next_step = r_step + 5'd1;
        unique case (r_step) inside
            STEP_ECHO: begin
                off  = r_job.echo_off;
                val  = r_job.echo_byte;
                last = !r_job.eop;
                next_step = r_job.ok ? STEP_HDR0 : STEP_DROP;
            end
            [STEP_HDR0:STEP_HDR_LAST]: begin
                // flags 0x8180, answer count, zero authority and additional counts
                case (hdr_idx)
                    3'd0:    begin off = 9'd2;  val = 8'h81; end
                    3'd1:    begin off = 9'd3;  val = 8'h80; end
                    3'd2:    begin off = 9'd6;  val = 8'h00; end
                    3'd3:    begin off = 9'd7;  val = {7'd0, r_job.is_a}; end
                    3'd4:    begin off = 9'd8;  val = 8'h00; end
                    3'd5:    begin off = 9'd9;  val = 8'h00; end
                    3'd6:    begin off = 9'd10; val = 8'h00; end
                    default: begin off = 9'd11; val = 8'h00; end
                endcase
                if (r_step == STEP_HDR_LAST) begin
                    next_step = r_job.is_a ? STEP_ANS0 : STEP_SEND;
                end
            end
            [STEP_ANS0:STEP_ANS_LAST]: begin
                // name pointer, type a, class in, ttl, length 4, address
                off = r_job.ans_off + 9'(ans_idx);
                case (ans_idx)
                    4'd0:    val = 8'hC0;
                    4'd1:    val = 8'h0C;
                    4'd2:    val = 8'h00;
                    4'd3:    val = 8'h01;
                    4'd4:    val = 8'h00;
                    4'd5:    val = 8'h01;
                    4'd6:    val = i_answer_ttl[31:24];
                    4'd7:    val = i_answer_ttl[23:16];
                    4'd8:    val = i_answer_ttl[15:8];
                    4'd9:    val = i_answer_ttl[7:0];
                    4'd10:   val = 8'h00;
                    4'd11:   val = 8'h04;
                    4'd12:   val = i_ap_address[31:24];
                    4'd13:   val = i_ap_address[23:16];
                    4'd14:   val = i_ap_address[15:8];
                    default: val = i_ap_address[7:0];
                endcase
            end
            STEP_SEND: begin
                act  = ACT_SEND;
                len  = r_job.rlen;
                last = 1'b1;
            end
            default: begin
                act  = ACT_DROP;
                last = 1'b1;
            end
        endcase
    end

    // next position of the sequencer
    always_comb begin
        if (i_load) begin
            n_step = start_step;
        end else if (fire && !last) begin
            n_step = next_step;
        end else begin
            n_step = r_step;
        end
    end

    // job register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_v <= 1'b0;
            r_step  <= STEP_ECHO;
        end else begin
            r_step <= n_step;
            if (i_load) begin
                r_job_v <= 1'b1;
            end else if (fire && last) begin
                r_job_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (out_load) begin
            r_m_tvalid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_m_tdata <= {5'd0, len, val, off};
            r_m_tuser <= act;
            r_m_tlast <= last;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;
    assign o_m_tlast  = r_m_tlast;

endmodule

@@ design/dns_redirect_responder.sv @@
// top level of the captive portal dns redirect responder
`timescale 1ns / 1ps

// Takes a DNS query one byte per item on the slave stream (tlast on the final byte)
// and emits byte writes that build the reply, then a send with the reply length or a
// drop. Query bytes are taken one per clock while the output is not stalled; a byte that
// is echoed or not gives at most one result, so a steady stream runs at one item per cycle.
// The final byte of a packet holds the result side for all its results (echo, eight header
// writes, sixteen answer writes for type A, send), one result per cycle through the output
// register unless i_m_tready stalls it, and no new byte is taken until its last result has
// been loaded. Configuration writes are always accepted and must only be made while no
// packet is in flight. There is no clearing pass after reset.

module dns_redirect_responder
    import dnsr_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // query stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte
    input  logic        i_s_tlast,   // end_of_packet
    // reply write stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // write_offset[8:0], write_byte[16:9], reply_length[26:17]
    output logic [1:0]  o_m_tuser,   // action
    output logic        o_m_tlast,   // final_result
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_ap_addr;
    logic [31:0] r_answer_ttl;
    t_job        job;
    logic        job_has;
    logic        accept;
    logic        emit_ready;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = emit_ready;
    assign accept      = i_s_tvalid && emit_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ap_addr    <= AP_ADDRESS_RESET;
            r_answer_ttl <= ANSWER_TTL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_AP_ADDRESS: r_ap_addr    <= i_cfg_data;
                CFG_ANSWER_TTL: r_answer_ttl <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // byte walker
    dnsr_parse #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_s_tdata),
        .i_end_of_packet(i_s_tlast),
        .o_job          (job),
        .o_job_has      (job_has)
    );

    // result sequencer
    dnsr_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept && job_has),
        .i_job       (job),
        .i_ap_address(r_ap_addr),
        .i_answer_ttl(r_answer_ttl),
        .o_ready     (emit_ready),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule
